[rtl/core/pd_pkg.sv]
// Shared types and constants for the 2x2 polar decomposition pipeline.
package pd_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned SqW      = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned QuoW     = 25;
  localparam int unsigned UnitW    = QuoW + 1;
  localparam int unsigned FracBits = 24;

  localparam logic signed [UnitW-1:0] OneQ24 = UnitW'(1) <<< FracBits;

  typedef struct packed {
    logic signed [DataW-1:0] f00;
    logic signed [DataW-1:0] f01;
    logic signed [DataW-1:0] f10;
    logic signed [DataW-1:0] f11;
    logic                    neg_x;
    logic                    neg_y;
    logic                    degen;
    logic [DataW-1:0]        ax;
    logic [DataW-1:0]        ay;
  } side_t;

endpackage

[rtl/core/polar_decomposition_2x2.sv]
// Top level of the fixed-point 2x2 polar decomposition pipeline.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | f_00 f_01 f_10 f_11
//  out     | output    | out_valid_o / out_stall_i | rot_00..rot_11 sym_00..sym_11
//          |           |                        | degenerate
//
// One item per cycle while the output is not stalled. The pipe has 5 front-end
// stages (sum, normalize in two steps, square, add), 32 square root stages (one
// root bit each), 25 divider stages (one quotient bit each) and 3 back-end stages.
// Reset clears only the valid bits. The whole pipe advances together and
// freezes while the output holds an item that is stalled; in_stall_o then
// rises so no item is lost or duplicated. Bubbles advance when not stalled.
module polar_decomposition_2x2 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [pd_pkg::DataW-1:0] f_00_i,
  input  logic signed [pd_pkg::DataW-1:0] f_01_i,
  input  logic signed [pd_pkg::DataW-1:0] f_10_i,
  input  logic signed [pd_pkg::DataW-1:0] f_11_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [pd_pkg::DataW-1:0] rot_00_o,
  output logic signed [pd_pkg::DataW-1:0] rot_01_o,
  output logic signed [pd_pkg::DataW-1:0] rot_10_o,
  output logic signed [pd_pkg::DataW-1:0] rot_11_o,
  output logic signed [pd_pkg::DataW-1:0] sym_00_o,
  output logic signed [pd_pkg::DataW-1:0] sym_01_o,
  output logic signed [pd_pkg::DataW-1:0] sym_10_o,
  output logic signed [pd_pkg::DataW-1:0] sym_11_o,
  output logic                            degenerate_o
);
  import pd_pkg::*;

  // global advance: only a stalled valid result holds the pipe
  logic en;
  assign en         = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = ~en;

  logic             norm_valid, sqrt_valid, div_valid;
  logic [SqW-1:0]   norm_n;
  logic [RootW-1:0] root;
  logic [QuoW-1:0]  qc, qs;
  side_t            norm_side, sqrt_side, div_side;

  pd_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .f_00_i  (f_00_i),
    .f_01_i  (f_01_i),
    .f_10_i  (f_10_i),
    .f_11_i  (f_11_i),
    .valid_o (norm_valid),
    .n_o     (norm_n),
    .side_o  (norm_side)
  );

  pd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .n_i     (norm_n),
    .side_i  (norm_side),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .side_o  (sqrt_side)
  );

  pd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .root_i  (root),
    .side_i  (sqrt_side),
    .valid_o (div_valid),
    .qc_o    (qc),
    .qs_o    (qs),
    .side_o  (div_side)
  );

  pd_stretch u_stretch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (div_valid),
    .qc_i         (qc),
    .qs_i         (qs),
    .side_i       (div_side),
    .valid_o      (out_valid_o),
    .rot_00_o     (rot_00_o),
    .rot_01_o     (rot_01_o),
    .rot_10_o     (rot_10_o),
    .rot_11_o     (rot_11_o),
    .sym_00_o     (sym_00_o),
    .sym_01_o     (sym_01_o),
    .sym_10_o     (sym_10_o),
    .sym_11_o     (sym_11_o),
    .degenerate_o (degenerate_o)
  );

  // degenerate items carry the identity rotation
  a_degen_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      rot_00_o == DataW'(OneQ24) && rot_10_o == '0)
    else $error("degenerate item without identity rotation");

  // cosine magnitude never exceeds one
  a_cos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rot_00_o <= DataW'(OneQ24) && rot_00_o >= -DataW'(OneQ24))
    else $error("cosine out of range");

  // rotation entries stay antisymmetric and diagonal equal
  a_rot_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rot_01_o == -rot_10_o && rot_00_o == rot_11_o)
    else $error("rotation shape broken");

endmodule

[rtl/core/pd_norm.sv]
// Front end: trace and skew terms, magnitude normalization, sum of squares.
module pd_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [pd_pkg::DataW-1:0] f_00_i,
  input  logic signed [pd_pkg::DataW-1:0] f_01_i,
  input  logic signed [pd_pkg::DataW-1:0] f_10_i,
  input  logic signed [pd_pkg::DataW-1:0] f_11_i,
  output logic                          valid_o,
  output logic [pd_pkg::SqW-1:0]        n_o,
  output pd_pkg::side_t                 side_o
);
  import pd_pkg::*;

  logic [4:0] vld_q;

  // stage 1: x, y and magnitudes
  logic signed [DataW:0] x_d, y_d;
  logic [DataW:0] ax1_q, ay1_q;
  side_t side1_q, side1_d;

  always_comb begin
    x_d = {f_00_i[DataW-1], f_00_i} + {f_11_i[DataW-1], f_11_i};
    y_d = {f_10_i[DataW-1], f_10_i} - {f_01_i[DataW-1], f_01_i};
    side1_d       = '0;
    side1_d.f00   = f_00_i;
    side1_d.f01   = f_01_i;
    side1_d.f10   = f_10_i;
    side1_d.f11   = f_11_i;
    side1_d.neg_x = x_d[DataW];
    side1_d.neg_y = y_d[DataW];
    side1_d.degen = (x_d == '0) && (y_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q   <= x_d[DataW] ? -x_d : x_d;
      ay1_q   <= y_d[DataW] ? -y_d : y_d;
      side1_q <= side1_d;
    end
  end

  // stage 2: right shift for large values, coarse left shifts by 16 and 8
  logic [DataW-1:0] ax2_d, ay2_d, m2_d, ax2_q, ay2_q, m2_q;
  logic [DataW:0]   m1;
  logic             big2_d, big2_q;
  side_t            side2_q;

  always_comb begin
    m1     = (ax1_q > ay1_q) ? ax1_q : ay1_q;
    big2_d = m1[DataW] | m1[DataW-1];
    if (big2_d) begin
      ax2_d = ax1_q[DataW:1];
      ay2_d = ay1_q[DataW:1];
      m2_d  = m1[DataW:1];
    end else begin
      ax2_d = ax1_q[DataW-1:0];
      ay2_d = ay1_q[DataW-1:0];
      m2_d  = m1[DataW-1:0];
      if (m2_d[30:15] == '0) begin
        ax2_d = ax2_d << 16;
        ay2_d = ay2_d << 16;
        m2_d  = m2_d << 16;
      end
      if (m2_d[30:23] == '0) begin
        ax2_d = ax2_d << 8;
        ay2_d = ay2_d << 8;
        m2_d  = m2_d << 8;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q   <= ax2_d;
      ay2_q   <= ay2_d;
      m2_q    <= m2_d;
      big2_q  <= big2_d;
      side2_q <= side1_q;
    end
  end

  // stage 3: fine left shifts by 4, 2 and 1
  logic [DataW-1:0] ax3_d, ay3_d, m3;
  side_t            side3_d, side3_q;

  always_comb begin
    ax3_d = ax2_q;
    ay3_d = ay2_q;
    m3    = m2_q;
    if (!big2_q) begin
      if (m3[30:27] == '0) begin
        ax3_d = ax3_d << 4;
        ay3_d = ay3_d << 4;
        m3    = m3 << 4;
      end
      if (m3[30:29] == '0) begin
        ax3_d = ax3_d << 2;
        ay3_d = ay3_d << 2;
        m3    = m3 << 2;
      end
      if (!m3[30]) begin
        ax3_d = ax3_d << 1;
        ay3_d = ay3_d << 1;
      end
    end
    side3_d    = side2_q;
    side3_d.ax = ax3_d;
    side3_d.ay = ay3_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side3_d;
    end
  end

  // stage 4: squares, stage 5: sum
  logic [SqW-1:0] sqx_q, sqy_q, n_q;
  side_t          side4_q, side5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= SqW'(side3_q.ax) * SqW'(side3_q.ax);
      sqy_q   <= SqW'(side3_q.ay) * SqW'(side3_q.ay);
      side4_q <= side3_q;
      n_q     <= sqx_q + sqy_q;
      side5_q <= side4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o = vld_q[4];
  assign n_o     = n_q;
  assign side_o  = side5_q;

endmodule

[rtl/core/pd_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module pd_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [pd_pkg::SqW-1:0] n_i,
  input  pd_pkg::side_t          side_i,
  output logic                   valid_o,
  output logic [pd_pkg::RootW-1:0] root_o,
  output pd_pkg::side_t          side_o
);
  import pd_pkg::*;

  localparam int unsigned RemW = RootW + 4;

  logic [RootW-1:0] vld_q;
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [SqW-1:0]   n_q    [RootW];
  side_t            side_q [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int unsigned Bit = RootW - 1 - j;
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic [RootW-1:0] root_in;
    logic [SqW-1:0]   n_in;
    side_t            side_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign n_in    = n_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], n_in[2*Bit+1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[j]  <= rem_sh - trial;
          root_q[j] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh;
          root_q[j] <= {root_in[RootW-2:0], 1'b0};
        end
        n_q[j]    <= n_in;
        side_q[j] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

[rtl/core/pd_div.sv]
// Pipelined restoring divider for the cosine and sine magnitudes, one bit per stage.
module pd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [pd_pkg::RootW-1:0] root_i,
  input  pd_pkg::side_t            side_i,
  output logic                     valid_o,
  output logic [pd_pkg::QuoW-1:0]  qc_o,
  output logic [pd_pkg::QuoW-1:0]  qs_o,
  output pd_pkg::side_t            side_o
);
  import pd_pkg::*;

  localparam int unsigned NumW = DataW + FracBits + 2;
  localparam int unsigned DenW = RootW + 1;

  logic [QuoW-1:0] vld_q;
  logic [NumW-1:0] remc_q [QuoW];
  logic [NumW-1:0] rems_q [QuoW];
  logic [QuoW-1:0] qc_q   [QuoW];
  logic [QuoW-1:0] qs_q   [QuoW];
  logic [DenW-1:0] den_q  [QuoW];
  side_t           side_q [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - j;
    logic [NumW-1:0] remc_in, rems_in;
    logic [QuoW-1:0] qc_in, qs_in;
    logic [DenW-1:0] den_in;
    logic [NumW:0]   dsh;
    side_t           side_in;

    if (j == 0) begin : g_first
      assign remc_in = (NumW'(side_i.ax) << (FracBits + 1)) + NumW'(root_i);
      assign rems_in = (NumW'(side_i.ay) << (FracBits + 1)) + NumW'(root_i);
      assign qc_in   = '0;
      assign qs_in   = '0;
      assign den_in  = {root_i, 1'b0};
      assign side_in = side_i;
    end else begin : g_next
      assign remc_in = remc_q[j-1];
      assign rems_in = rems_q[j-1];
      assign qc_in   = qc_q[j-1];
      assign qs_in   = qs_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign dsh = (NumW+1)'(den_in) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, remc_in} >= dsh) begin
          remc_q[j] <= remc_in - dsh[NumW-1:0];
          qc_q[j]   <= qc_in | (QuoW'(1) << Bit);
        end else begin
          remc_q[j] <= remc_in;
          qc_q[j]   <= qc_in;
        end
        if ({1'b0, rems_in} >= dsh) begin
          rems_q[j] <= rems_in - dsh[NumW-1:0];
          qs_q[j]   <= qs_in | (QuoW'(1) << Bit);
        end else begin
          rems_q[j] <= rems_in;
          qs_q[j]   <= qs_in;
        end
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuoW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign qc_o    = qc_q[QuoW-1];
  assign qs_o    = qs_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

[rtl/core/pd_stretch.sv]
// Back end: signed rotation entries, S = R^T * F products, rounding and saturation.
module pd_stretch (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [pd_pkg::QuoW-1:0]         qc_i,
  input  logic [pd_pkg::QuoW-1:0]         qs_i,
  input  pd_pkg::side_t                   side_i,
  output logic                            valid_o,
  output logic signed [pd_pkg::DataW-1:0] rot_00_o,
  output logic signed [pd_pkg::DataW-1:0] rot_01_o,
  output logic signed [pd_pkg::DataW-1:0] rot_10_o,
  output logic signed [pd_pkg::DataW-1:0] rot_11_o,
  output logic signed [pd_pkg::DataW-1:0] sym_00_o,
  output logic signed [pd_pkg::DataW-1:0] sym_01_o,
  output logic signed [pd_pkg::DataW-1:0] sym_10_o,
  output logic signed [pd_pkg::DataW-1:0] sym_11_o,
  output logic                            degenerate_o
);
  import pd_pkg::*;

  localparam int unsigned ProdW = UnitW + DataW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned ShW   = SumW - FracBits;

  logic [2:0] vld_q;

  // stage A: apply signs, identity for the degenerate case
  logic signed [UnitW-1:0] c_a_q, s_a_q;
  side_t side_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (side_i.degen) begin
        c_a_q <= OneQ24;
        s_a_q <= '0;
      end else begin
        c_a_q <= side_i.neg_x ? -$signed({1'b0, qc_i}) : $signed({1'b0, qc_i});
        s_a_q <= side_i.neg_y ? -$signed({1'b0, qs_i}) : $signed({1'b0, qs_i});
      end
      side_a_q <= side_i;
    end
  end

  // stage B: eight products
  logic signed [ProdW-1:0] p_q [8];
  logic signed [UnitW-1:0] c_b_q, s_b_q;
  logic degen_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= ProdW'(c_a_q) * ProdW'(side_a_q.f00);
      p_q[1] <= ProdW'(s_a_q) * ProdW'(side_a_q.f10);
      p_q[2] <= ProdW'(c_a_q) * ProdW'(side_a_q.f01);
      p_q[3] <= ProdW'(s_a_q) * ProdW'(side_a_q.f11);
      p_q[4] <= -(ProdW'(s_a_q) * ProdW'(side_a_q.f00));
      p_q[5] <= ProdW'(c_a_q) * ProdW'(side_a_q.f10);
      p_q[6] <= -(ProdW'(s_a_q) * ProdW'(side_a_q.f01));
      p_q[7] <= ProdW'(c_a_q) * ProdW'(side_a_q.f11);
      c_b_q     <= c_a_q;
      s_b_q     <= s_a_q;
      degen_b_q <= side_a_q.degen;
    end
  end

  // stage C: sum, round half up, saturate
  logic signed [DataW-1:0] sym_d [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [SumW-1:0] v;
      logic signed [ShW-1:0]  q;
      v = SumW'(p_q[2*k]) + SumW'(p_q[2*k+1]) + (SumW'(1) <<< (FracBits - 1));
      q = ShW'(v >>> FracBits);
      if (q > ShW'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
        sym_d[k] = {1'b0, {(DataW-1){1'b1}}};
      end else if (q < -ShW'(signed'({1'b0, {(DataW-1){1'b1}}})) - ShW'(1)) begin
        sym_d[k] = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        sym_d[k] = q[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_00_o     <= DataW'(c_b_q);
      rot_01_o     <= DataW'(-s_b_q);
      rot_10_o     <= DataW'(s_b_q);
      rot_11_o     <= DataW'(c_b_q);
      sym_00_o     <= sym_d[0];
      sym_01_o     <= sym_d[1];
      sym_10_o     <= sym_d[2];
      sym_11_o     <= sym_d[3];
      degenerate_o <= degen_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];

endmodule

[tb/sv/polar_decomposition_2x2_tb.sv]
// Self-checking testbench for the 2x2 fixed-point polar decomposition pipeline.
`timescale 1ns / 100ps

module polar_decomposition_2x2_tb;

  localparam int unsigned DW = pd_pkg::DataW;
  localparam int NumRandom   = 650;
  localparam int Latency     = 65;
  localparam int IdleLimit   = 20000;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    word_t f00;
    word_t f01;
    word_t f10;
    word_t f11;
  } mat_t;

  typedef struct packed {
    word_t r00;
    word_t r01;
    word_t r10;
    word_t r11;
    word_t s00;
    word_t s01;
    word_t s10;
    word_t s11;
    logic  degen;
  } polar_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  word_t f00, f01, f10, f11;
  word_t rot00, rot01, rot10, rot11, sym00, sym01, sym10, sym11;
  logic degen;

  mat_t   pending_mats[$];
  polar_t expected_polar[$];
  int     n_fail, n_checked, n_degen, n_sat;
  int     idle_cycles;
  bit     hold_off;
  bit     hold_taken;

  polar_decomposition_2x2 dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .f_00_i(f00), .f_01_i(f01), .f_10_i(f10), .f_11_i(f11),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rot_00_o(rot00), .rot_01_o(rot01), .rot_10_o(rot10), .rot_11_o(rot11),
    .sym_00_o(sym00), .sym_01_o(sym01), .sym_10_o(sym10), .sym_11_o(sym11),
    .degenerate_o(degen)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Bitwise integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Magnitude / root, rounded to nearest, then signed.
  function automatic logic signed [63:0] unit_ratio(input logic [63:0] mag, input logic neg,
                                                    input logic [63:0] r);
    logic [63:0] q;
    q = ((mag << 25) + r) / (r << 1);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Sum of two Q8.24 products, rounded (ties up) and saturated; flags clipping.
  function automatic word_t stretch_entry(input logic signed [63:0] a, input word_t fa,
                                          input logic signed [63:0] b, input word_t fb,
                                          inout int sat);
    logic signed [127:0] v;
    logic signed [127:0] q;
    v = a * 128'(signed'(fa)) + b * 128'(signed'(fb)) + 128'sd8388608;
    q = v >>> 24;  // arithmetic shift is floor
    if (q > 128'sd2147483647) begin
      sat++;
      return 32'h7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat++;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic polar_t decompose(input mat_t m, inout int sat);
    polar_t p;
    logic signed [63:0] x, y, c, s;
    logic [63:0] ax, ay, mx, r;
    x = 64'(m.f00) + 64'(m.f11);
    y = 64'(m.f10) - 64'(m.f01);
    c = 64'sd16777216;
    s = 0;
    p.degen = (x == 0) && (y == 0);
    if (!p.degen) begin
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      mx = ax > ay ? ax : ay;
      if (mx >= (64'd1 << 31)) begin
        ax = ax >> 1;
        ay = ay >> 1;
      end else begin
        while (mx < (64'd1 << 30)) begin
          mx = mx << 1;
          ax = ax << 1;
          ay = ay << 1;
        end
      end
      r = floor_sqrt(ax * ax + ay * ay);
      c = unit_ratio(ax, x < 0, r);
      s = unit_ratio(ay, y < 0, r);
    end
    p.r00 = c[31:0];
    p.r01 = -s[31:0];
    p.r10 = s[31:0];
    p.r11 = c[31:0];
    p.s00 = stretch_entry(c, m.f00, s, m.f10, sat);
    p.s01 = stretch_entry(c, m.f01, s, m.f11, sat);
    p.s10 = stretch_entry(-s, m.f00, c, m.f10, sat);
    p.s11 = stretch_entry(-s, m.f01, c, m.f11, sat);
    return p;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? 32'sd16777216 : -32'sd16777216;
      3: return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom();
    endcase
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued items with random gaps; payload holds while stalled.
  int send_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      f00 <= '0; f01 <= '0; f10 <= '0; f11 <= '0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      // current item (if any) accepted at this edge, or nothing offered
      if (in_valid) begin
        expected_polar.push_back(decompose({f00, f01, f10, f11}, n_sat));
      end
      if (send_gap > 0 || pending_mats.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        mat_t m;
        m = pending_mats.pop_front();
        in_valid <= 1'b1;
        {f00, f01, f10, f11} <= m;
        send_gap <= gap_len();
      end
    end
  end

  // Receiver stall: random gaps, plus one long hold-off counted here when requested.
  int stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_off && !hold_taken) begin
      out_stall <= 1'b1;
      stall_left <= 4 * Latency;
      hold_taken <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      int g;
      g = $urandom_range(0, 3) == 0 ? gap_len() : 0;
      out_stall <= (g > 0);
      stall_left <= g > 0 ? g - 1 : 0;
    end
  end

  // Monitor: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_polar.size() == 0) begin
          $error("result with no item pending");
          n_fail++;
        end else begin
          polar_t e;
          e = expected_polar.pop_front();
          n_checked++;
          if (e.degen) n_degen++;
          if (rot00 !== e.r00) begin $error("rot_00 exp %0d got %0d", e.r00, rot00); n_fail++; end
          if (rot01 !== e.r01) begin $error("rot_01 exp %0d got %0d", e.r01, rot01); n_fail++; end
          if (rot10 !== e.r10) begin $error("rot_10 exp %0d got %0d", e.r10, rot10); n_fail++; end
          if (rot11 !== e.r11) begin $error("rot_11 exp %0d got %0d", e.r11, rot11); n_fail++; end
          if (sym00 !== e.s00) begin $error("sym_00 exp %0d got %0d", e.s00, sym00); n_fail++; end
          if (sym01 !== e.s01) begin $error("sym_01 exp %0d got %0d", e.s01, sym01); n_fail++; end
          if (sym10 !== e.s10) begin $error("sym_10 exp %0d got %0d", e.s10, sym10); n_fail++; end
          if (sym11 !== e.s11) begin $error("sym_11 exp %0d got %0d", e.s11, sym11); n_fail++; end
          if (degen !== e.degen) begin
            $error("degenerate exp %0b got %0b", e.degen, degen);
            n_fail++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no progress in %0d cycles", IdleLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    mat_t m;
    n_fail = 0; n_checked = 0; n_degen = 0; n_sat = 0;
    idle_cycles = 0; hold_off = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, zero, degenerate cases, extremes, pure rotations.
    pending_mats.push_back('{32'sd16777216, 0, 0, 32'sd16777216});
    pending_mats.push_back('{0, 0, 0, 0});
    pending_mats.push_back('{32'sd5, 32'sd7, 32'sd7, -32'sd5});      // x=0, y=0
    pending_mats.push_back('{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
    pending_mats.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff});
    pending_mats.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000});
    pending_mats.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    pending_mats.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
    pending_mats.push_back('{0, -32'sd16777216, 32'sd16777216, 0});  // 90 degrees
    pending_mats.push_back('{0, 32'sd16777216, -32'sd16777216, 0});  // -90 degrees
    pending_mats.push_back('{-32'sd16777216, 0, 0, -32'sd16777216}); // 180 degrees
    pending_mats.push_back('{32'sd1, 0, 0, 0});                      // tiny x
    pending_mats.push_back('{0, 0, 32'sd1, 0});                      // tiny y
    pending_mats.push_back('{32'sd3, 32'sd1, 32'sd2, 32'sd1});       // rounding ties
    pending_mats.push_back('{32'h40000000, 32'h40000000, 32'h40000000, 32'h40000000});
    pending_mats.push_back('{32'hffffffff, 32'h00000000, 32'hffffffff, 32'hffffffff});
    pending_mats.push_back('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa});
    pending_mats.push_back('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});

    for (int i = 0; i < NumRandom; i++) begin
      m = '{rand_word(), rand_word(), rand_word(), rand_word()};
      if ($urandom_range(0, 19) == 0) m.f11 = -m.f00;   // x = 0
      if ($urandom_range(0, 19) == 0) m.f10 = m.f01;    // y = 0
      if ($urandom_range(0, 29) == 0) begin             // degenerate
        m.f11 = -m.f00;
        m.f10 = m.f01;
      end
      pending_mats.push_back(m);
      // Long receiver hold-off midway while the sender keeps offering items.
      if (i == NumRandom / 3) begin
        while (pending_mats.size() > 0) @(posedge clk);
        for (int j = 0; j < 2 * Latency; j++) begin
          pending_mats.push_back('{rand_word(), rand_word(), rand_word(), rand_word()});
        end
        hold_off = 1'b1;
        wait (hold_taken);
        wait (stall_left == 0);
        hold_off = 1'b0;
      end
    end

    while (pending_mats.size() > 0 || in_valid) @(posedge clk);
    while (expected_polar.size() > 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    $display("checked %0d results, %0d degenerate, %0d saturated stretch entries",
             n_checked, n_degen, n_sat);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pd_pkg.sv
rtl/core/pd_norm.sv
rtl/core/pd_sqrt.sv
rtl/core/pd_div.sv
rtl/core/pd_stretch.sv
rtl/core/polar_decomposition_2x2.sv
tb/sv/polar_decomposition_2x2_tb.sv
